[rtl/core/csi_pkg.sv]
// Shared constants and register codes for the coprime stride shuffle index block.
// No dependencies; imported by every module under rtl/core.
package csi_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IDX_OUT_W = 16;
  localparam int unsigned CFG_IDX_W = 4;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_SHUFFLE_SEED = cfg_idx_t'(0);
  localparam cfg_idx_t REG_ITEM_COUNT   = cfg_idx_t'(1);

  localparam word_t SEED_RESET  = 32'h9e37_79b9;
  localparam word_t MIX_MUL_A   = 32'h7feb_352d;
  localparam word_t MIX_MUL_B   = 32'h846c_a68b;
  localparam word_t STRIDE_SALT = 32'h85eb_ca6b;
  localparam word_t OFFSET_SALT = 32'hc2b2_ae35;

endpackage

[rtl/core/csi_hash.sv]
// 32-bit xor-shift / multiply mixing hash, multiplies done bit-serially.
// Depends on csi_pkg. A hash runs two bit-serial multiply passes after go_i, then a done pulse.
module csi_hash import csi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  go_i,
  input  word_t data_i,
  output logic  done_o,
  output word_t hash_o
);

  typedef enum logic [1:0] {H_IDLE, H_MUL_A, H_MUL_B} hstate_e;

  localparam int unsigned CNT_W = $clog2(WORD_W);

  hstate_e          state_q;
  word_t            a_q, b_q, acc_q, res_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  word_t acc_sum, mix_mid, mix_end;

  // shift-add: multiplicand shifts left, multiplier shifts right (LSB first)
  assign acc_sum = acc_q + (b_q[0] ? a_q : '0);
  assign mix_mid = acc_sum ^ (acc_sum >> 15);
  assign mix_end = acc_sum ^ (acc_sum >> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      a_q     <= '0;
      b_q     <= '0;
      acc_q   <= '0;
      res_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        a_q     <= data_i ^ (data_i >> 16);
        b_q     <= MIX_MUL_A;
        acc_q   <= '0;
        cnt_q   <= CNT_W'(WORD_W - 1);
        state_q <= H_MUL_A;
      end else begin
        unique case (state_q)
          H_IDLE: begin
          end
          H_MUL_A, H_MUL_B: begin
            acc_q <= acc_sum;
            a_q   <= a_q << 1;
            b_q   <= b_q >> 1;
            cnt_q <= cnt_q - 1'b1;
            if (cnt_q == '0) begin
              if (state_q == H_MUL_A) begin
                a_q     <= mix_mid;
                b_q     <= MIX_MUL_B;
                acc_q   <= '0;
                cnt_q   <= CNT_W'(WORD_W - 1);
                state_q <= H_MUL_B;
              end else begin
                res_q   <= mix_end;
                done_q  <= 1'b1;
                state_q <= H_IDLE;
              end
            end
          end
          default: state_q <= H_IDLE;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign hash_o = res_q;

endmodule

[rtl/core/csi_mod.sv]
// Bit-serial restoring remainder: dividend mod divisor, one dividend bit per cycle.
// Depends on csi_pkg; divisor must be nonzero.
module csi_mod import csi_pkg::*; #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic [DW-1:0] num_i,
  input  logic [VW-1:0] div_i,
  output logic          done_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(DW);

  logic [DW-1:0]    num_q;
  logic [VW-1:0]    div_q, rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;

  logic [VW:0] trial, trial_sub;

  // partial remainder stays below the divisor, so one compare-subtract per bit
  assign trial     = {rem_q, num_q[DW-1]};
  assign trial_sub = (trial >= {1'b0, div_q}) ? (trial - {1'b0, div_q}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        num_q <= num_i;
        div_q <= div_i;
        rem_q <= '0;
        cnt_q <= CNT_W'(DW - 1);
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= trial_sub[VW-1:0];
        num_q <= num_q << 1;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[rtl/core/csi_gcd.sv]
// Binary (shift-subtract) coprime test of two nonzero values, one step per cycle.
// Depends on csi_pkg. Done pulse with coprime_o valid when the test ends.
module csi_gcd import csi_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         go_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         done_o,
  output logic         coprime_o
);

  logic [W-1:0] a_q, b_q;
  logic         run_q, done_q, ok_q;
  logic [W-1:0] a_minus_b, b_minus_a;

  assign a_minus_b = a_q - b_q;
  assign b_minus_a = b_q - a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      ok_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        a_q   <= a_i;
        b_q   <= b_i;
        run_q <= 1'b1;
      end else if (run_q) begin
        priority if (a_q == '0) begin
          ok_q   <= (b_q == W'(1));
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else if (b_q == '0) begin
          ok_q   <= (a_q == W'(1));
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else if (!a_q[0] && !b_q[0]) begin
          // common factor of two
          ok_q   <= 1'b0;
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else if (!a_q[0]) begin
          a_q <= a_q >> 1;
        end else if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else if (a_q >= b_q) begin
          a_q <= a_minus_b >> 1;
        end else begin
          b_q <= b_minus_a >> 1;
        end
      end
    end
  end

  assign done_o    = done_q;
  assign coprime_o = ok_q;

endmodule

[rtl/core/coprime_stride_shuffle_index.sv]
// Coprime stride shuffle index: offset + (position mod n) * stride, mod n.
// When item_count < 2 the index comes out on the next cycle; otherwise the result waits on
// the bit-serial hash multiplier, the remainder unit and the gcd stepper (once per stride trial).
// One word in flight; busy held meanwhile.
// Reset: seed = 0x9e3779b9, item_count = 0, sequencer idle. Results cannot be stalled.
module coprime_stride_shuffle_index import csi_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_W-1:0]    position_i,
  output logic                 out_valid_o,
  output logic [IDX_OUT_W-1:0] shuffled_index_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  cfg_idx_t             cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  localparam int unsigned CW    = (COUNT_BITS < IDX_OUT_W) ? COUNT_BITS : IDX_OUT_W;
  localparam int unsigned BIT_W = $clog2(CW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_HASH_OFF, ST_MOD_OFF, ST_HASH_STR, ST_MOD_STR,
    ST_GCD, ST_MOD_POS, ST_MULMOD, ST_ADD_OFF
  } state_e;

  state_e           state_q;
  word_t            seed_q, pos_q, hash_in_q, mod_num_q;
  logic [CW-1:0]    count_q, mod_div_q, off_q, stride_q, p_q, acc_q, idx_q;
  logic [BIT_W-1:0] bit_q;
  logic             hash_go_q, mod_go_q, gcd_go_q, vld_q;

  logic          hash_done, mod_done, gcd_done, gcd_ok;
  word_t         hash_res;
  logic [CW-1:0] mod_rem;

  csi_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (hash_go_q),
    .data_i (hash_in_q),
    .done_o (hash_done),
    .hash_o (hash_res)
  );

  csi_mod #(.DW(WORD_W), .VW(CW)) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mod_go_q),
    .num_i  (mod_num_q),
    .div_i  (mod_div_q),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  csi_gcd #(.W(CW)) u_gcd (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (gcd_go_q),
    .a_i       (stride_q),
    .b_i       (count_q),
    .done_o    (gcd_done),
    .coprime_o (gcd_ok)
  );

  // modular multiply step (MSB first), final offset add, stride bump
  logic [CW:0] dbl, dbl_red, addv, add_red, fin, fin_red, str_inc;

  assign dbl     = {acc_q, 1'b0};
  assign dbl_red = (dbl >= {1'b0, count_q}) ? (dbl - {1'b0, count_q}) : dbl;
  assign addv    = {1'b0, dbl_red[CW-1:0]} + (p_q[CW-1] ? {1'b0, stride_q} : '0);
  assign add_red = (addv >= {1'b0, count_q}) ? (addv - {1'b0, count_q}) : addv;
  assign fin     = {1'b0, acc_q} + {1'b0, off_q};
  assign fin_red = (fin >= {1'b0, count_q}) ? (fin - {1'b0, count_q}) : fin;
  assign str_inc = {1'b0, stride_q} + (CW+1)'(1);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= SEED_RESET;
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SHUFFLE_SEED: seed_q  <= cfg_data_i;
        REG_ITEM_COUNT:   count_q <= cfg_data_i[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      hash_in_q <= '0;
      mod_num_q <= '0;
      mod_div_q <= '0;
      off_q     <= '0;
      stride_q  <= '0;
      p_q       <= '0;
      acc_q     <= '0;
      idx_q     <= '0;
      bit_q     <= '0;
      hash_go_q <= 1'b0;
      mod_go_q  <= 1'b0;
      gcd_go_q  <= 1'b0;
      vld_q     <= 1'b0;
    end else begin
      hash_go_q <= 1'b0;
      mod_go_q  <= 1'b0;
      gcd_go_q  <= 1'b0;
      vld_q     <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            pos_q <= position_i;
            if (count_q < CW'(2)) begin
              idx_q <= '0;
              vld_q <= 1'b1;
            end else begin
              hash_in_q <= seed_q ^ OFFSET_SALT;
              hash_go_q <= 1'b1;
              state_q   <= ST_HASH_OFF;
            end
          end
        end
        ST_HASH_OFF: begin
          if (hash_done) begin
            mod_num_q <= hash_res;
            mod_div_q <= count_q;
            mod_go_q  <= 1'b1;
            state_q   <= ST_MOD_OFF;
          end
        end
        ST_MOD_OFF: begin
          if (mod_done) begin
            off_q     <= mod_rem;
            hash_in_q <= seed_q ^ STRIDE_SALT;
            hash_go_q <= 1'b1;
            state_q   <= ST_HASH_STR;
          end
        end
        ST_HASH_STR: begin
          if (hash_done) begin
            mod_num_q <= hash_res;
            mod_div_q <= count_q - 1'b1;
            mod_go_q  <= 1'b1;
            state_q   <= ST_MOD_STR;
          end
        end
        ST_MOD_STR: begin
          if (mod_done) begin
            stride_q <= mod_rem + 1'b1;
            gcd_go_q <= 1'b1;
            state_q  <= ST_GCD;
          end
        end
        ST_GCD: begin
          if (gcd_done) begin
            if (gcd_ok) begin
              mod_num_q <= pos_q;
              mod_div_q <= count_q;
              mod_go_q  <= 1'b1;
              state_q   <= ST_MOD_POS;
            end else begin
              // next candidate, wrapping back to one at the count
              stride_q <= (str_inc >= {1'b0, count_q}) ? CW'(1) : str_inc[CW-1:0];
              gcd_go_q <= 1'b1;
            end
          end
        end
        ST_MOD_POS: begin
          if (mod_done) begin
            p_q     <= mod_rem;
            acc_q   <= '0;
            bit_q   <= BIT_W'(CW - 1);
            state_q <= ST_MULMOD;
          end
        end
        ST_MULMOD: begin
          acc_q <= add_red[CW-1:0];
          p_q   <= p_q << 1;
          bit_q <= bit_q - 1'b1;
          if (bit_q == '0) begin
            state_q <= ST_ADD_OFF;
          end
        end
        ST_ADD_OFF: begin
          idx_q   <= fin_red[CW-1:0];
          vld_q   <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy             = (state_q != ST_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = vld_q;
  assign shuffled_index_o = IDX_OUT_W'(idx_q);

  // a result word only appears once the sequencer is back in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy)
    else $error("result strobe while busy");

  // the hash unit only reports while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> (state_q == ST_HASH_OFF || state_q == ST_HASH_STR))
    else $error("hash done outside a hash wait");

  // stride candidates are never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GCD) |-> (stride_q != '0))
    else $error("zero stride candidate");

  // counts below two give index zero on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && count_q < CW'(2)) |=> (out_valid_o && shuffled_index_o == '0))
    else $error("small count did not give index zero");

endmodule

[test/coprime_stride_shuffle_index_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for coprime_stride_shuffle_index: queued commands and register writes,
// an in-bench index predictor and a result scoreboard. Depends on csi_pkg and the block RTL.
module coprime_stride_shuffle_index_test;
  import csi_pkg::*;

  localparam cfg_idx_t REG_FIRST_UNUSED = cfg_idx_t'(2);
  localparam int unsigned TAIL_CYCLES = 2000;

  typedef logic [IDX_OUT_W-1:0] index_t;

  // one queued word: a register write or a position command
  typedef struct packed {
    logic     is_write;
    cfg_idx_t reg_index;
    word_t    value;
    logic [4:0] idle_after;
  } shuffle_cmd_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     start       = 1'b0;
  logic     busy;
  word_t    position_i  = '0;
  logic     out_valid_o;
  index_t   shuffled_index_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  cfg_idx_t cfg_index_i = REG_SHUFFLE_SEED;
  word_t    cfg_data_i  = '0;

  logic item_taken  = 1'b0;
  logic write_taken = 1'b0;

  shuffle_cmd_t pending_cmds[$];
  index_t       expected_index[$];

  word_t model_seed  = SEED_RESET;
  word_t model_count = '0;

  int          mismatch_count = 0;
  int          idle_left      = 0;
  int unsigned item_total     = 0;
  int unsigned idle_odds      = 4;
  bit          quiet_tail     = 1'b0;

  coprime_stride_shuffle_index uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .shuffled_index_o (shuffled_index_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic word_t mix32(input word_t v);
    word_t h;
    h = v ^ (v >> 16);
    h = h * MIX_MUL_A;
    h = h ^ (h >> 15);
    h = h * MIX_MUL_B;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic word_t gcd_u32(input word_t a, input word_t b);
    word_t x, y, r;
    x = a;
    y = b;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic index_t predict_shuffled_index(input word_t pos);
    word_t n, off, stride;
    logic [63:0] idx;
    n = model_count;
    if (n < 2) return '0;
    off = mix32(model_seed ^ OFFSET_SALT) % n;
    stride = (mix32(model_seed ^ STRIDE_SALT) % (n - 1)) + 1;
    while (gcd_u32(stride, n) != 1) begin
      stride = stride + 1;
      if (stride >= n) stride = 1;
    end
    idx = (64'(off) + 64'(pos % n) * 64'(stride)) % 64'(n);
    return idx[IDX_OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input index_t got_v, input index_t exp_v);
    $display("[%0t] MISMATCH %s: shuffled_index got %0d expected %0d", $time, what,
             got_v, exp_v);
    mismatch_count++;
  endtask

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin : monitor
    index_t exp_v;
    if (rst_ni) begin
      item_taken  <= start && !busy;
      write_taken <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SHUFFLE_SEED: model_seed = cfg_data_i;
          REG_ITEM_COUNT:   model_count = word_t'(cfg_data_i[IDX_OUT_W-1:0]);
          default: ;
        endcase
      end
      if (start && !busy) expected_index = {expected_index, predict_shuffled_index(position_i)};
      if (out_valid_o) begin
        if (expected_index.size() == 0) begin
          report_mismatch("result with nothing outstanding", shuffled_index_o, '0);
        end else begin
          exp_v = expected_index.pop_front();
          if (shuffled_index_o !== exp_v) report_mismatch("wrong index", shuffled_index_o, exp_v);
        end
      end
    end
  end

  // ---------------- driver ----------------
  always @(negedge clk_i) begin : driver
    shuffle_cmd_t head;
    logic next_start, next_write, launch;
    if (rst_ni) begin
      next_start = start && !item_taken;
      next_write = cfg_valid_i && !write_taken;
      launch     = 1'b0;
      head       = '0;
      if (!next_start && !next_write) begin
        if (idle_left > 0) begin
          idle_left = idle_left - 1;
        end else if (pending_cmds.size() > 0) begin
          head = pending_cmds[0];
          // register writes only go out once the block has drained
          if (!head.is_write || (expected_index.size() == 0 && !busy)) begin
            void'(pending_cmds.pop_front());
            launch    = 1'b1;
            idle_left = int'(head.idle_after);
            if (head.is_write) next_write = 1'b1;
            else next_start = 1'b1;
          end
        end
      end
      start       <= next_start;
      cfg_valid_i <= next_write;
      if (launch && head.is_write) begin
        cfg_index_i <= head.reg_index;
        cfg_data_i  <= head.value;
      end else if (launch) begin
        position_i <= head.value;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [4:0] pick_idle();
    if (quiet_tail || idle_odds == 0) return '0;
    if ($urandom_range(0, idle_odds - 1) == 0) return 5'($urandom_range(1, 16));
    return '0;
  endfunction

  task automatic enqueue_cmd(input shuffle_cmd_t cmd);
    pending_cmds = {pending_cmds, cmd};
  endtask

  task automatic add_write(input cfg_idx_t idx, input word_t data);
    enqueue_cmd('{is_write: 1'b1, reg_index: idx, value: data, idle_after: pick_idle()});
  endtask

  task automatic add_item(input word_t pos);
    enqueue_cmd('{is_write: 1'b0, reg_index: REG_SHUFFLE_SEED, value: pos,
                  idle_after: pick_idle()});
    item_total++;
  endtask

  task automatic add_unused_write();
    add_write(cfg_idx_t'($urandom_range(int'(REG_FIRST_UNUSED), (1 << CFG_IDX_W) - 1)),
              $urandom());
  endtask

  // count value the last queued write leaves in the register
  function automatic int unsigned model_count_of_last_write();
    shuffle_cmd_t last;
    last = pending_cmds[pending_cmds.size() - 1];
    return int'(last.value[IDX_OUT_W-1:0]);
  endfunction

  initial begin : stimulus
    int unsigned n, phase_len, base, sel;

    // reset values: count of zero gives index 0
    add_item('0);
    add_item('1);
    // reset seed with a real count
    add_write(REG_ITEM_COUNT, 32'd10);
    add_item(32'd0);
    add_item(32'd9);
    add_item(32'd10);
    add_item('1);
    // count of one
    add_write(REG_ITEM_COUNT, 32'd1);
    add_item($urandom());
    // count of two: stride always 1
    add_write(REG_SHUFFLE_SEED, '0);
    add_write(REG_ITEM_COUNT, 32'd2);
    add_item(32'd0);
    add_item(32'd1);
    // bits above the register width are dropped (count becomes 3)
    add_write(REG_SHUFFLE_SEED, '1);
    add_write(REG_ITEM_COUNT, 32'hffff_0003);
    add_item(32'd0);
    add_item(32'd1);
    add_item(32'd2);
    // largest count
    add_write(REG_ITEM_COUNT, 32'd65535);
    add_item(32'd0);
    add_item(32'd65534);
    add_item(32'd65535);
    add_item('1);
    // many small prime factors: long coprime search
    add_write(REG_SHUFFLE_SEED, $urandom());
    add_write(REG_ITEM_COUNT, 32'd30030);
    add_item($urandom());
    add_item($urandom());
    // truncation to zero
    add_write(REG_ITEM_COUNT, 32'h0001_0000);
    add_item($urandom());
    // writes past the register list are ignored
    add_write(REG_ITEM_COUNT, 32'd7);
    add_unused_write();
    add_item(32'd6);
    add_item($urandom());

    while (item_total < 900) begin
      idle_odds  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
      quiet_tail = (item_total >= 820);
      if ($urandom_range(0, 3) != 0) add_write(REG_SHUFFLE_SEED, $urandom());
      if ($urandom_range(0, 7) == 0) add_unused_write();
      sel = $urandom_range(0, 9);
      case (sel)
        0: begin
          case ($urandom_range(0, 3))
            0: n = 0;
            1: n = 1;
            2: n = 2;
            default: n = 65535;
          endcase
          add_write(REG_ITEM_COUNT, word_t'(n));
        end
        1, 2, 3, 4: begin
          n = $urandom_range(3, 40);
          add_write(REG_ITEM_COUNT, word_t'(n));
        end
        5, 6, 7, 8: begin
          n = $urandom_range(2, 65535);
          add_write(REG_ITEM_COUNT, word_t'(n));
        end
        default: begin
          add_write(REG_ITEM_COUNT, $urandom());
          n = model_count_of_last_write();
        end
      endcase
      if (n >= 2 && n <= 40 && $urandom_range(0, 3) != 0) begin
        // one full cycle of positions starting on a multiple of the count
        base = $urandom_range(0, 32'hffff_ffff / n - 1);
        for (int unsigned j = 0; j < n; j++) add_item(word_t'(base * n + j));
      end else begin
        phase_len = $urandom_range(8, 40);
        for (int unsigned j = 0; j < phase_len; j++) begin
          case ($urandom_range(0, 7))
            0: add_item(word_t'(32'hffff_ffff - $urandom_range(0, 3)));
            1: add_item(word_t'($urandom_range(0, 70000)));
            default: add_item($urandom());
          endcase
        end
      end
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start || cfg_valid_i || expected_index.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("coprime_stride_shuffle_index_test passed");
    end else begin
      $display("coprime_stride_shuffle_index_test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("coprime_stride_shuffle_index_test failed");
    $finish;
  end

endmodule
